// ----- design/sdz_pkg.sv -----
// Shared constants, widths and types for the stick deadzone scaler.
package sdz_pkg;

    // Axis full scale, used both for the magnitude clamp and as the transfer scale
    localparam int AXIS_MAX = 32767;

    localparam int RAW_W   = 16;
    localparam int MAG16_W = 15;   // clamped magnitude
    localparam int DZOFF_W = 22;   // dz * AXIS_MAX
    localparam int DLT_W   = 24;   // 100*m - dz*AXIS_MAX, signed
    localparam int TERM1_W = 29;   // adz * AXIS_MAX * (100 - dz)
    localparam int SUM_W   = 31;   // signed inner sum
    localparam int NUM_W   = 40;   // signed numerator
    localparam int MAG_W   = 39;   // |numerator|
    localparam int DEN_W   = 20;   // 10000 * (100 - dz)
    localparam int QUO_W   = 15;   // quotient bits below the saturation bit
    localparam int REM_W   = DEN_W + QUO_W;

    typedef struct packed {
        logic [DZOFF_W-1:0] dz_off;
        logic               dz_full;
        logic signed [7:0]  adz_fac;
        logic [8:0]         sens;
        logic               inv_y;
        logic [DEN_W-1:0]   den;
        logic [TERM1_W-1:0] term1;
    } cfg_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
        logic             zero;
    } div_axis_t;

    typedef struct packed {
        div_axis_t x;
        div_axis_t y;
    } div_pair_t;

endpackage

// ----- design/stick_deadzone_scaler_unit.sv -----
// Top level of the stick deadzone scaler: front pipeline, divider cell row, output register.
//
//  channel | signals                              | dir | notes
//  --------+--------------------------------------+-----+------------------------------
//  in      | in_valid, in_stall, raw_x, raw_y     | in  | item taken on valid && !stall
//  out     | out_valid, out_stall, x_out, y_out   | out | item taken on valid && !stall
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | in  | write on valid && ready
//
// One item per cycle while out_stall is low; registers in order: input reg,
// deadzone offset, anti-deadzone multiply, gain multiply, magnitude/saturation
// check, 15 divider cells (one quotient bit each), output reg.
// Reset empties every stage and loads register defaults (sensitivity 100).
// Each stage holds its item while the next is full and cannot move on; a stalled output
// backs the row up one stage at a time, so empty slots are filled and in_stall rises last.
// cfg_ready is always high; derived config terms settle in the cycle after a write.
module stick_deadzone_scaler_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] raw_x,
    input  logic signed [15:0] raw_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] x_out,
    output logic signed [15:0] y_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import sdz_pkg::*;

    localparam int NCELL = QUO_W;

    cfg_t cfg;

    sdz_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stage valids and readies
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg, out_valid_reg;
    logic a_ready, b_ready, c_ready, d_ready, e_ready, o_ready;

    // per-axis payload, index 0 = X, 1 = Y
    logic signed [RAW_W-1:0] raw_reg  [2];
    logic signed [DLT_W-1:0] dlt_reg  [2];
    logic signed [DLT_W-1:0] dlt_next [2];
    logic signed [SUM_W-1:0] sum_reg  [2];
    logic signed [SUM_W-1:0] sum_next [2];
    logic signed [NUM_W-1:0] num_reg  [2];
    logic signed [NUM_W-1:0] num_next [2];
    logic                    b_neg_reg [2], c_neg_reg [2], d_neg_reg [2];
    logic                    b_zero_reg [2], c_zero_reg [2], d_zero_reg [2];
    logic                    zero_next [2];
    div_axis_t               e_next [2];
    div_pair_t               e_data_reg;
    logic signed [15:0]      res_reg  [2];
    logic signed [15:0]      res_next [2];

    // divider row links
    logic      link_valid [NCELL+1];
    logic      link_ready [NCELL+1];
    div_pair_t link_data  [NCELL+1];

    assign o_ready  = !out_valid_reg || !out_stall;
    assign e_ready  = !e_valid_reg || link_ready[0];
    assign d_ready  = !d_valid_reg || e_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_stall = !a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready) a_valid_reg   <= in_valid;
            if (b_ready) b_valid_reg   <= a_valid_reg;
            if (c_ready) c_valid_reg   <= b_valid_reg;
            if (d_ready) d_valid_reg   <= c_valid_reg;
            if (e_ready) e_valid_reg   <= d_valid_reg;
            if (o_ready) out_valid_reg <= link_valid[NCELL];
        end
    end

    // Stage B: clamp magnitude, offset by the deadzone edge
    always_comb
    begin
        logic [RAW_W:0]      absv;
        logic [MAG16_W-1:0]  m;
        logic [DZOFF_W-1:0]  m100;
        for (int k = 0; k < 2; k++)
        begin
            absv = raw_reg[k][RAW_W-1] ? (17'd0 - 17'(raw_reg[k])) : 17'(raw_reg[k]);
            m    = (absv > 17'(AXIS_MAX)) ? MAG16_W'(AXIS_MAX) : absv[MAG16_W-1:0];
            m100 = DZOFF_W'(m) * DZOFF_W'(100);
            dlt_next[k]  = $signed({2'b00, m100}) - $signed({2'b00, cfg.dz_off});
            zero_next[k] = cfg.dz_full || dlt_next[k][DLT_W-1];
        end
    end

    // Stage C: anti-deadzone blend; Stage D: gain
    always_comb
    begin
        logic signed [31:0] term2;
        for (int k = 0; k < 2; k++)
        begin
            term2       = 32'(cfg.adz_fac) * 32'(dlt_reg[k]);
            sum_next[k] = SUM_W'(term2) + $signed({2'b00, cfg.term1});
            num_next[k] = NUM_W'($signed({1'b0, cfg.sens})) * NUM_W'(sum_reg[k]);
        end
    end

    // Stage E: magnitude, final sign, saturation at bit 15 of the quotient
    always_comb
    begin
        logic [NUM_W-1:0] mag;
        for (int k = 0; k < 2; k++)
        begin
            mag = num_reg[k][NUM_W-1] ? (NUM_W'(0) - NUM_W'(num_reg[k])) : NUM_W'(num_reg[k]);
            e_next[k].ovf  = mag[MAG_W-1:0] >= MAG_W'({cfg.den, {QUO_W{1'b0}}});
            e_next[k].rem  = mag[REM_W-1:0];
            e_next[k].quo  = '0;
            e_next[k].neg  = num_reg[k][NUM_W-1] ^ d_neg_reg[k] ^ ((k == 1) && cfg.inv_y);
            e_next[k].zero = d_zero_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            raw_reg[0] <= raw_x;
            raw_reg[1] <= raw_y;
        end
        if (b_ready && a_valid_reg)
        begin
            for (int k = 0; k < 2; k++)
            begin
                dlt_reg[k]    <= dlt_next[k];
                b_neg_reg[k]  <= raw_reg[k][RAW_W-1];
                b_zero_reg[k] <= zero_next[k];
            end
        end
        if (c_ready && b_valid_reg)
        begin
            for (int k = 0; k < 2; k++)
            begin
                sum_reg[k]    <= sum_next[k];
                c_neg_reg[k]  <= b_neg_reg[k];
                c_zero_reg[k] <= b_zero_reg[k];
            end
        end
        if (d_ready && c_valid_reg)
        begin
            for (int k = 0; k < 2; k++)
            begin
                num_reg[k]    <= num_next[k];
                d_neg_reg[k]  <= c_neg_reg[k];
                d_zero_reg[k] <= c_zero_reg[k];
            end
        end
        if (e_ready && d_valid_reg)
        begin
            e_data_reg.x <= e_next[0];
            e_data_reg.y <= e_next[1];
        end
        if (o_ready && link_valid[NCELL])
        begin
            res_reg[0] <= res_next[0];
            res_reg[1] <= res_next[1];
        end
    end

    assign link_valid[0] = e_valid_reg;
    assign link_data[0]  = e_data_reg;

    // Divider row: cell j resolves quotient bit QUO_W-1-j
    for (genvar j = 0; j < NCELL; j++)
    begin : g_cell
        sdz_div_cell #(
            .BIT (QUO_W - 1 - j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[j]),
            .in_ready  (link_ready[j]),
            .in_data   (link_data[j]),
            .den       (cfg.den),
            .out_valid (link_valid[j+1]),
            .out_ready (link_ready[j+1]),
            .out_data  (link_data[j+1])
        );
    end

    assign link_ready[NCELL] = o_ready;

    // Output: zero region, saturation, sign
    always_comb
    begin
        div_axis_t          ax;
        logic signed [15:0] v;
        for (int k = 0; k < 2; k++)
        begin
            ax = (k == 0) ? link_data[NCELL].x : link_data[NCELL].y;
            priority if (ax.zero) v = '0;
            else if (ax.ovf)      v = 16'(AXIS_MAX);
            else                  v = $signed({1'b0, ax.quo});
            res_next[k] = ax.neg ? (16'sd0 - v) : v;
        end
    end

    assign out_valid = out_valid_reg;
    assign x_out     = res_reg[0];
    assign y_out     = res_reg[1];

    // full-scale negative code never appears: saturation is symmetric
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (x_out != 16'sh8000) && (y_out != 16'sh8000))
        else $error("output reached -32768");

    // a stall at the input means the first two stages are both occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (a_valid_reg && b_valid_reg))
        else $error("input stalled with room in the pipeline");

    // divisor derived from config is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg.den != '0)
        else $error("zero divisor");

    // an item leaving the last stage is buffered or delivered, never dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (link_valid[NCELL] && o_ready) |=> out_valid)
        else $error("result lost at output register");

endmodule

// ----- design/sdz_cfg_regs.sv -----
// Configuration registers and the per-setting derived terms.
module sdz_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    output sdz_pkg::cfg_t cfg
);
    import sdz_pkg::*;

    localparam logic [7:0] REG_DEADZONE      = 8'd0;
    localparam logic [7:0] REG_ANTI_DEADZONE = 8'd1;
    localparam logic [7:0] REG_SENSITIVITY   = 8'd2;
    localparam logic [7:0] REG_INVERT_Y      = 8'd3;

    logic [6:0] dz_reg;
    logic [6:0] adz_reg;
    logic [8:0] sens_reg;
    logic       inv_reg;
    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [6:0] dz_span;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg   <= '0;
            adz_reg  <= '0;
            sens_reg <= 9'd100;
            inv_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DEADZONE:      dz_reg   <= cfg_data[6:0];
                REG_ANTI_DEADZONE: adz_reg  <= cfg_data[6:0];
                REG_SENSITIVITY:   sens_reg <= cfg_data[8:0];
                REG_INVERT_Y:      inv_reg  <= cfg_data[0];
                default:           ;  // unknown index: ignored
            endcase
        end
    end

    // Derived terms follow the raw registers in the next cycle, through cfg_reg
    always_comb
    begin
        cfg_next.dz_full = (dz_reg >= 7'd100);
        dz_span          = cfg_next.dz_full ? 7'd1 : (7'd100 - dz_reg);
        cfg_next.dz_off  = DZOFF_W'(dz_reg) * DZOFF_W'(AXIS_MAX);
        cfg_next.adz_fac = 8'sd100 - $signed({1'b0, adz_reg});
        cfg_next.sens    = sens_reg;
        cfg_next.inv_y   = inv_reg;
        cfg_next.den     = DEN_W'(dz_span) * DEN_W'(10000);
        cfg_next.term1   = (TERM1_W'(adz_reg) * TERM1_W'(AXIS_MAX)) * TERM1_W'(dz_span);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dz_off  <= '0;
            cfg_reg.dz_full <= 1'b0;
            cfg_reg.adz_fac <= 8'sd100;
            cfg_reg.sens    <= 9'd100;
            cfg_reg.inv_y   <= 1'b0;
            cfg_reg.den     <= DEN_W'(1000000);
            cfg_reg.term1   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/sdz_div_cell.sv -----
// One restoring-divide cell: resolves one quotient bit for both axes.
module sdz_div_cell #(
    parameter int BIT = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  sdz_pkg::div_pair_t        in_data,
    input  logic [sdz_pkg::DEN_W-1:0] den,
    output logic                      out_valid,
    input  logic                      out_ready,
    output sdz_pkg::div_pair_t        out_data
);
    import sdz_pkg::*;

    logic       valid_reg;
    div_pair_t  data_reg;
    div_pair_t  data_next;
    logic [REM_W-1:0] trial;

    assign trial    = REM_W'(den) << BIT;
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next = in_data;
        if (in_data.x.rem >= trial)
        begin
            data_next.x.rem      = in_data.x.rem - trial;
            data_next.x.quo[BIT] = 1'b1;
        end
        if (in_data.y.rem >= trial)
        begin
            data_next.y.rem      = in_data.y.rem - trial;
            data_next.y.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- tb/sv/stick_deadzone_scaler_unit_tb.sv -----
// Testbench for the stick deadzone scaler: directed and random sample pairs checked per axis.
`timescale 1ns / 100ps

module stick_deadzone_scaler_unit_tb;

    // register indexes of the config channel
    localparam logic [7:0] REG_DEADZONE  = 8'd0;
    localparam logic [7:0] REG_ANTI_DZ   = 8'd1;
    localparam logic [7:0] REG_SENS      = 8'd2;
    localparam logic [7:0] REG_INVERT_Y  = 8'd3;
    localparam logic [7:0] REG_UNUSED    = 8'd9;
    localparam int         PIPE_LATENCY  = 21;
    localparam longint     AXIS_FULL     = 32767;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         cfg_index;
    logic [15:0]        cfg_data;

    // Predictor copy of the config registers
    logic [6:0] dz_pct;
    logic [6:0] adz_pct;
    logic [8:0] gain_pct;
    logic       flip_y;

    // Expected conditioned pairs, oldest first
    logic signed [15:0] pending_x[$];
    logic signed [15:0] pending_y[$];

    int error_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;

    stick_deadzone_scaler_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .raw_x     (raw_x),
        .raw_y     (raw_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .x_out     (x_out),
        .y_out     (y_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Per-axis transfer curve, exact integer math
    function automatic logic signed [15:0] shape_axis(logic signed [15:0] raw);
        longint dz;
        longint adz;
        longint gain;
        longint mag;
        longint v;
        dz   = dz_pct;
        adz  = adz_pct;
        gain = gain_pct;
        mag  = (raw < 0) ? -longint'(raw) : longint'(raw);
        if (mag > AXIS_FULL)
            mag = AXIS_FULL;
        if (dz >= 100)
            return 16'sd0;
        if (100 * mag < dz * AXIS_FULL)
            return 16'sd0;
        v = gain * (adz * AXIS_FULL * (100 - dz) + (100 - adz) * (100 * mag - dz * AXIS_FULL))
            / (10000 * (100 - dz));
        if (v > AXIS_FULL)
            v = AXIS_FULL;
        if (v < -AXIS_FULL)
            v = -AXIS_FULL;
        if (raw < 0)
            v = -v;
        return 16'(v);
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Send one sample pair; queue its expectation on acceptance
    task automatic send_sample(input logic signed [15:0] sx, input logic signed [15:0] sy);
        logic signed [15:0] ey;
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid = 1'b1;
        raw_x    = sx;
        raw_y    = sy;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ey = shape_axis(sy);
        if (flip_y)
            ey = -ey;
        pending_x.push_back(shape_axis(sx));
        pending_y.push_back(ey);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Wait until the pipe is empty; then config writes are safe
    task automatic drain;
        int guard;
        guard = 0;
        while (pending_x.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (PIPE_LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_DEADZONE: dz_pct   = val[6:0];
            REG_ANTI_DZ:  adz_pct  = val[6:0];
            REG_SENS:     gain_pct = val[8:0];
            REG_INVERT_Y: flip_y   = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
        // derived terms settle in the cycle after the write
        repeat (2) @(negedge clk);
    endtask

    task automatic set_curve(input int dz, input int adz, input int gain, input bit inv);
        drain();
        write_reg(REG_DEADZONE, 16'(dz));
        write_reg(REG_ANTI_DZ, 16'(adz));
        write_reg(REG_SENS, 16'(gain));
        write_reg(REG_INVERT_Y, 16'(inv));
    endtask

    // Raw values weighted toward the edges, the deadzone edge and zero
    function automatic logic signed [15:0] pick_raw();
        int sel;
        int edge_mag;
        sel = $urandom_range(9);
        edge_mag = (int'(dz_pct) * 32767) / 100;
        if (sel == 0)
            return 16'sh8000;
        if (sel == 1)
            return 16'($urandom_range(1) ? 32767 : -32767);
        if (sel == 2 && edge_mag <= 32767)
        begin
            edge_mag = edge_mag + int'($urandom_range(4)) - 2;
            return 16'($urandom_range(1) ? edge_mag : -edge_mag);
        end
        if (sel == 3)
            return 16'($urandom_range(8)) - 16'sd4;
        return 16'($urandom);
    endfunction

    task automatic test_directed;
        logic signed [15:0] edge_vals[10];
        edge_vals = '{16'sh8000, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767,
                      16'sd100, -16'sd16384, 16'sd16384, 16'sh5555};
        // reset defaults: unity gain, no deadzone
        foreach (edge_vals[i])
            send_sample(edge_vals[i], edge_vals[9 - i]);
        // anti-deadzone offset at raw zero
        set_curve(0, 30, 100, 0);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sh8000, 16'sd0);
        // anti-deadzone above 100 turns the blend factor negative
        set_curve(10, 127, 400, 1);
        send_sample(16'sd32767, -16'sd32767);
        send_sample(16'sd3276, 16'sd3277);
        // full deadzone and beyond
        set_curve(100, 50, 400, 1);
        send_sample(16'sd32767, 16'sh8000);
        set_curve(127, 0, 511, 0);
        send_sample(16'sd32767, -16'sd5);
        // deadzone edge, gain zero, ignored register
        set_curve(20, 0, 0, 1);
        send_sample(16'sd6553, 16'sd6554);
        set_curve(20, 5, 250, 1);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_sample(16'sd6553, -16'sd6554);
        send_sample(16'sd6554, -16'sd32767);
    endtask

    task automatic test_random_block(input int count);
        set_curve($urandom_range(127), $urandom_range(127), $urandom_range(511),
                  $urandom_range(1));
        repeat (count)
            send_sample(pick_raw(), pick_raw());
    endtask

    task automatic test_random_idling;
        send_idle_pct = 25;
        recv_idle_pct = 55;
        repeat (6) test_random_block(78);
        send_idle_pct = 55;
        recv_idle_pct = 25;
        repeat (6) test_random_block(78);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (6) test_random_block(78);
        // extreme settings
        set_curve(0, 0, 511, 1);
        repeat (60) send_sample(pick_raw(), pick_raw());
        set_curve(99, 100, 1, 0);
        repeat (60) send_sample(pick_raw(), pick_raw());
    endtask

    // Receiver holds off for a long stretch while the sender keeps pushing,
    // so the pipe fills and in_stall must rise
    task automatic test_backpressure;
        set_curve(40, 20, 150, 0);
        hold_cycles = 150;
        repeat (60) send_sample(pick_raw(), pick_raw());
        drain();
        repeat (40) send_sample(pick_raw(), pick_raw());
    endtask

    // Receiver: random stall, long hold-off counted down in cycles
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_x.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                if (x_out !== pending_x[0])
                    report_mismatch($sformatf("x_out %0d, expected %0d", x_out, pending_x[0]));
                if (y_out !== pending_y[0])
                    report_mismatch($sformatf("y_out %0d, expected %0d", y_out, pending_y[0]));
                void'(pending_x.pop_front());
                void'(pending_y.pop_front());
            end
        end
    end

    initial
    begin
        in_valid      = 1'b0;
        raw_x         = '0;
        raw_y         = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        out_stall     = 1'b0;
        hold_cycles   = 0;
        error_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        dz_pct        = 7'd0;
        adz_pct       = 7'd0;
        gain_pct      = 9'd100;
        flip_y        = 1'b0;
        rst_n         = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_backpressure();
        test_random_idling();

        drain();
        if (error_count == 0 && pending_x.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
